[rtl/btsx_pkg.sv]
// Shared constants and types for the binary trie subarray XOR extrema block.
// No dependencies; compiled first.
`default_nettype none

package btsx_pkg;

   localparam int KEY_BITS   = 21;
   localparam int NODE_COUNT = 131072;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int NEXT_W     = NODE_W + 1;
   localparam int LVL_W      = $clog2(KEY_BITS + 1);

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [NEXT_W-1:0]   next_type;
   typedef logic [LVL_W-1:0]    lvl_type;

   // Both children of one trie node; zero means no child.
   typedef struct packed {
      node_type c1;
      node_type c0;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINK,
      ST_ALLOC,
      ST_MAX,
      ST_MIN,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/btsx_if.sv]
// Valid/ready channels for requests and results of the trie XOR block.
// Depends on btsx_pkg.
`default_nettype none

interface btsx_req_if;
   import btsx_pkg::*;

   logic    valid;
   logic    ready;
   key_type value;
   logic    first_item;

   modport source (output valid, output value, output first_item, input ready);
   modport sink   (input valid, input value, input first_item, output ready);
endinterface

interface btsx_rsp_if;
   import btsx_pkg::*;

   logic    valid;
   logic    ready;
   key_type prefix_xor;
   key_type end_max;
   key_type end_min;
   key_type best_max;
   key_type best_min;
   logic    pool_full;

   modport source (output valid, output prefix_xor, output end_max, output end_min,
                   output best_max, output best_min, output pool_full, input ready);
   modport sink   (input valid, input prefix_xor, input end_max, input end_min,
                   input best_max, input best_min, input pool_full, output ready);
endinterface

`default_nettype wire

[rtl/binary_trie_subarray_xor_extrema.sv]
// Each request XORs its value into the running prefix, then walks the trie of earlier
// prefixes one key bit per cycle, once for the largest XOR and once for the smallest,
// and then makes up to 22 writes to append the new prefix, one trie row per cycle, through
// a single memory read port and write port. A request with first_item set first inserts
// prefix 0 into the cleared trie. The result waits in an output register, so the next
// request is taken while it is unread.
// No clearing pass: the root lives in flip-flops and other rows are written when allocated.
// Depends on btsx_pkg and btsx_if.
`default_nettype none

module binary_trie_subarray_xor_extrema (
   input  wire logic   clock,
   input  wire logic   reset,
   btsx_req_if.sink    req_port,
   btsx_rsp_if.source  rsp_port
);
   import btsx_pkg::*;

   function automatic row_type set_child(row_type row, logic bit_sel, node_type node);
      row_type r;
      r = row;
      if (bit_sel) r.c1 = node;
      else         r.c0 = node;
      return r;
   endfunction

   state_type state_ff, state_in;

   key_type  prefix_ff, prefix_in;
   key_type  key_ff, key_in;
   key_type  res_ff, res_in;
   key_type  emax_ff, emax_in;
   key_type  run_max_ff, run_max_in;
   key_type  run_min_ff, run_min_in;
   node_type node_ff, node_in;
   lvl_type  lvl_ff, lvl_in;
   row_type  root_ff, root_in;
   next_type next_ff, next_in;

   logic     div_ff, div_in;
   node_type pend_node_ff, pend_node_in;
   row_type  pend_row_ff, pend_row_in;
   key_type  ins_ff, ins_in;
   lvl_type  cnt_ff, cnt_in;
   logic     post_ff, post_in;
   logic     drop_ff, drop_in;

   logic     rsp_valid_ff, rsp_valid_in;
   key_type  out_prefix_ff, out_max_ff, out_min_ff, out_best_max_ff, out_best_min_ff;
   logic     out_full_ff;

   row_type  trie_mem [NODE_COUNT];
   row_type  rd_row_ff;
   logic     mem_we;
   node_type mem_waddr;
   row_type  mem_wrow;

   logic     req_take, rsp_load;
   row_type  cur_row;
   logic     kbit;
   node_type same_child, other_child;
   logic     fits;
   logic     last_lvl;

   // Current node's children: the root is held in flip-flops.
   assign cur_row     = (node_ff == '0) ? root_ff : rd_row_ff;
   assign kbit        = key_ff[KEY_BITS-1];
   assign same_child  = kbit ? cur_row.c1 : cur_row.c0;
   assign other_child = kbit ? cur_row.c0 : cur_row.c1;
   assign last_lvl    = (lvl_ff == '0);
   assign fits        = ({1'b0, next_ff} + (NEXT_W+1)'(cnt_ff)) <= (NEXT_W+1)'(NODE_COUNT);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) state_in = req_port.first_item ? ST_LINK : ST_MAX;
         end
         ST_LINK:  state_in = ST_ALLOC;
         ST_ALLOC: begin
            if (cnt_ff == lvl_type'(1)) state_in = post_ff ? ST_DONE : ST_MAX;
         end
         ST_MAX: begin
            if (last_lvl) state_in = ST_MIN;
         end
         ST_MIN: begin
            if (last_lvl) state_in = ST_CHECK;
         end
         ST_CHECK: state_in = (div_ff && fits) ? ST_LINK : ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- FSM outputs ----------------
   always_comb begin
      req_take = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: req_take = req_port.valid;
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_port.ready;
         default: begin
            req_take = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   assign req_port.ready = (state_ff == ST_IDLE);

   // ---------------- datapath ----------------
   always_comb begin
      prefix_in    = prefix_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      emax_in      = emax_ff;
      run_max_in   = run_max_ff;
      run_min_in   = run_min_ff;
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      root_in      = root_ff;
      next_in      = next_ff;
      div_in       = div_ff;
      pend_node_in = pend_node_ff;
      pend_row_in  = pend_row_ff;
      ins_in       = ins_ff;
      cnt_in       = cnt_ff;
      post_in      = post_ff;
      drop_in      = drop_ff;
      mem_we       = 1'b0;
      mem_waddr    = next_ff[NODE_W-1:0];
      mem_wrow     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prefix_in = (req_port.first_item ? '0 : prefix_ff) ^ req_port.value;
               key_in    = prefix_in;
               node_in   = '0;
               lvl_in    = lvl_type'(KEY_BITS - 1);
               drop_in   = 1'b0;
               if (req_port.first_item) begin
                  // new sequence: empty trie, then insert prefix 0 before the walks
                  root_in      = '0;
                  next_in      = next_type'(1);
                  run_max_in   = '0;
                  run_min_in   = '1;
                  pend_node_in = '0;
                  pend_row_in  = '0;
                  ins_in       = '0;
                  cnt_in       = lvl_type'(KEY_BITS);
                  post_in      = 1'b0;
               end
            end
         end
         ST_LINK: begin
            // hang the first new node under the node where the path ended
            mem_wrow  = set_child(pend_row_ff, ins_ff[KEY_BITS-1], next_ff[NODE_W-1:0]);
            mem_waddr = pend_node_ff;
            if (pend_node_ff == '0) root_in = mem_wrow;
            else                    mem_we  = 1'b1;
            ins_in = {ins_ff[KEY_BITS-2:0], 1'b0};
         end
         ST_ALLOC: begin
            mem_we    = 1'b1;
            mem_waddr = next_ff[NODE_W-1:0];
            if (cnt_ff != lvl_type'(1))
               mem_wrow = set_child('0, ins_ff[KEY_BITS-1], next_ff[NODE_W-1:0] + 1'b1);
            next_in = next_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
            ins_in  = {ins_ff[KEY_BITS-2:0], 1'b0};
            node_in = '0;
            lvl_in  = lvl_type'(KEY_BITS - 1);
         end
         ST_MAX: begin
            key_in = {key_ff[KEY_BITS-2:0], key_ff[KEY_BITS-1]};
            if (other_child != '0) begin
               res_in  = {res_ff[KEY_BITS-2:0], 1'b1};
               node_in = other_child;
            end else begin
               res_in  = {res_ff[KEY_BITS-2:0], 1'b0};
               node_in = same_child;
            end
            lvl_in = lvl_ff - 1'b1;
            if (last_lvl) begin
               emax_in = res_in;
               node_in = '0;
               lvl_in  = lvl_type'(KEY_BITS - 1);
               div_in  = 1'b0;
            end
         end
         ST_MIN: begin
            key_in = {key_ff[KEY_BITS-2:0], key_ff[KEY_BITS-1]};
            if (same_child != '0) begin
               res_in  = {res_ff[KEY_BITS-2:0], 1'b0};
               node_in = same_child;
            end else begin
               res_in  = {res_ff[KEY_BITS-2:0], 1'b1};
               node_in = other_child;
               // the insert path leaves the trie at the first missing same-bit child
               if (!div_ff) begin
                  div_in       = 1'b1;
                  pend_node_in = node_ff;
                  pend_row_in  = cur_row;
                  ins_in       = key_ff;
                  cnt_in       = lvl_ff + 1'b1;
               end
            end
            lvl_in = lvl_ff - 1'b1;
         end
         ST_CHECK: begin
            if (emax_ff > run_max_ff) run_max_in = emax_ff;
            if (res_ff < run_min_ff)  run_min_in = res_ff;
            if (div_ff && !fits) drop_in = 1'b1;
            post_in = 1'b1;
         end
         ST_DONE: begin
            node_in = node_ff;
         end
         default: begin
            node_in = node_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)                rsp_valid_in = 1'b1;
      else if (rsp_port.ready)     rsp_valid_in = 1'b0;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_ff      <= '0;
         next_ff      <= next_type'(1);
         prefix_ff    <= '0;
         run_max_ff   <= '0;
         run_min_ff   <= '1;
         rsp_valid_ff <= 1'b0;
         div_ff       <= 1'b0;
         post_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         lvl_ff       <= '0;
         cnt_ff       <= '0;
         node_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         next_ff      <= next_in;
         prefix_ff    <= prefix_in;
         run_max_ff   <= run_max_in;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         post_ff      <= post_in;
         drop_ff      <= drop_in;
         lvl_ff       <= lvl_in;
         cnt_ff       <= cnt_in;
         node_ff      <= node_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      res_ff       <= res_in;
      emax_ff      <= emax_in;
      pend_node_ff <= pend_node_in;
      pend_row_ff  <= pend_row_in;
      ins_ff       <= ins_in;
      if (rsp_load) begin
         out_prefix_ff   <= prefix_ff;
         out_max_ff      <= emax_ff;
         out_min_ff      <= res_ff;
         out_best_max_ff <= run_max_ff;
         out_best_min_ff <= run_min_ff;
         out_full_ff     <= drop_ff;
      end
   end

   // Trie rows; row 0 is unused (root is in flip-flops).
   always_ff @(posedge clock) begin
      if (mem_we) trie_mem[mem_waddr] <= mem_wrow;
      rd_row_ff <= trie_mem[node_in];
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.prefix_xor = out_prefix_ff;
   assign rsp_port.end_max    = out_max_ff;
   assign rsp_port.end_min    = out_min_ff;
   assign rsp_port.best_max   = out_best_max_ff;
   assign rsp_port.best_min   = out_best_min_ff;
   assign rsp_port.pool_full  = out_full_ff;

   // ---------------- assertions ----------------
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= next_type'(NODE_COUNT))
      else $error("node allocator ran past the pool");

   a_link_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK |->
         ({1'b0, next_ff} + (NEXT_W+1)'(cnt_ff)) <= (NEXT_W+1)'(NODE_COUNT))
      else $error("insert started without room in the pool");

   a_alloc_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC |-> cnt_ff != '0)
      else $error("allocation with no nodes left to write");

   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAX && !last_lvl) |=> (state_ff == ST_MAX && lvl_ff == $past(lvl_ff) - 1'b1))
      else $error("max walk skipped a level");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

endmodule

`default_nettype wire
